// ===== src/lssfg_pkg.sv =====
// Shared types and constants for the LED strip stripe frame generator.
// No dependencies; every other file refers to this package by scoped names.
package lssfg_pkg;

  localparam int MAX_LEDS      = 1024;
  localparam int PALETTE_DEPTH = 16;
  localparam int CNT_W         = 11;   // LED position, lengths, phase offset
  localparam int PER_W         = 12;   // stripe plus gap, pattern counter
  localparam int PIX_W         = 4;    // palette index
  localparam int PLEN_W        = 5;    // palette length
  localparam int ENTRY_W       = 29;   // brightness 5, red, green, blue
  localparam int WORD_W        = 32;
  localparam int MOD_STEPS     = 11;   // one remainder bit per step
  localparam int STEP_W        = 4;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  localparam logic [2:0]        LED_HDR    = 3'b111;
  localparam logic [4:0]        BR_MAX     = 5'd31;
  localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
  localparam logic [WORD_W-1:0] DARK_WORD  = 32'hE000_0000;
  localparam logic [WORD_W-1:0] END_WORD   = 32'hFFFF_FFFF;

  typedef enum logic {
    OP_PAL_WR  = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_LED   = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_LED_COUNT    = 3'd0,
    REG_STRIPE_LEN   = 3'd1,
    REG_GAP_LEN      = 3'd2,
    REG_PHASE_OFFSET = 3'd3,
    REG_COLOR_OFFSET = 3'd4,
    REG_PALETTE_LEN  = 3'd5
  } reg_idx_t;

  typedef enum logic {
    ST_RUN  = 1'b0,
    ST_WAIT = 1'b1
  } back_state_t;

  typedef struct packed {
    op_t                op;
    logic [PIX_W-1:0]   idx;
    logic [ENTRY_W-1:0] entry;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  led_count;
    logic [CNT_W-1:0]  stripe_len;
    logic [CNT_W-1:0]  gap_len;
    logic [CNT_W-1:0]  phase_offset;
    logic [PIX_W-1:0]  color_offset;
    logic [PLEN_W-1:0] palette_len;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [PER_W-1:0]  period;
    logic [CNT_W-1:0]  phase;
    logic [PIX_W-1:0]  coff;
    logic [PLEN_W-1:0] plen;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [PER_W-1:0] pat;
    logic [PIX_W-1:0] col;
  } mod_rsp_t;

endpackage

// ===== src/led_strip_stripe_frame_generator.sv =====
// Top level of the LED strip stripe frame generator.
// Depends on lssfg_pkg, lssfg_cfg, lssfg_front, lssfg_fifo, lssfg_mod, lssfg_back.
//
// Each input word with tuser 0 loads one palette entry (brightness clamped
// to 31); each input word with tuser 1 produces the next 32-bit word of the
// current frame: an all-zero start word, one word per LED (lit stripe LEDs
// carry 0xE0|brightness, blue, green, red; gap LEDs carry 0xE0000000), then
// an all-ones end word with tlast set. A front stage registers and classifies
// input words and hands them through a two-entry queue to the back part, which
// owns the palette, the frame counters and the output register, so each side
// stalls on its own. Queued palette loads retire at one per clock, LED and end
// words at one per clock while the output is not stalled. A start word goes out
// at once, but the back part then waits while the iterative remainder unit
// (11 restoring steps) reduces phase_offset and color_offset before it takes
// the next queued word. There is no clearing pass after reset: palette entries
// hold garbage until loaded. Write configuration only while the block is idle.
module led_strip_stripe_frame_generator (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // palette_index[3:0], brightness[11:4], red[19:12],
                                  // green[27:20], blue[35:28], zero[39:36]
  input  logic        in_tuser,   // func[0]
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // spi_word[31:0]
  output logic [1:0]  out_tuser,  // word_kind[1:0]
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  lssfg_pkg::cfg_t     cfg;
  lssfg_pkg::cmd_t     push_cmd, pop_cmd;
  lssfg_pkg::mod_req_t mod_req;
  lssfg_pkg::mod_rsp_t mod_rsp;
  lssfg_pkg::kind_t    out_kind;
  logic                push_valid, push_ready, pop_valid, pop;

  assign out_tuser = out_kind;

  lssfg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lssfg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_func    (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lssfg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  lssfg_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  lssfg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata),
    .out_kind  (out_kind),
    .out_last  (out_tlast)
  );

endmodule

// ===== src/lssfg_cfg.sv =====
// Configuration register file behind the APB-style port.
// Depends on lssfg_pkg.
module lssfg_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lssfg_pkg::ADDR_W-1:0] paddr,
  input  logic [lssfg_pkg::DATA_W-1:0] pwdata,
  output logic [lssfg_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output lssfg_pkg::cfg_t              cfg
);

  lssfg_pkg::cfg_t      cfg_r, cfg_nxt;
  lssfg_pkg::reg_idx_t  idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = lssfg_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        lssfg_pkg::REG_LED_COUNT:    cfg_nxt.led_count    = pwdata[10:0];
        lssfg_pkg::REG_STRIPE_LEN:   cfg_nxt.stripe_len   = pwdata[10:0];
        lssfg_pkg::REG_GAP_LEN:      cfg_nxt.gap_len      = pwdata[10:0];
        lssfg_pkg::REG_PHASE_OFFSET: cfg_nxt.phase_offset = pwdata[10:0];
        lssfg_pkg::REG_COLOR_OFFSET: cfg_nxt.color_offset = pwdata[3:0];
        lssfg_pkg::REG_PALETTE_LEN:  cfg_nxt.palette_len  = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lssfg_pkg::REG_LED_COUNT:    prdata = 32'(cfg_r.led_count);
      lssfg_pkg::REG_STRIPE_LEN:   prdata = 32'(cfg_r.stripe_len);
      lssfg_pkg::REG_GAP_LEN:      prdata = 32'(cfg_r.gap_len);
      lssfg_pkg::REG_PHASE_OFFSET: prdata = 32'(cfg_r.phase_offset);
      lssfg_pkg::REG_COLOR_OFFSET: prdata = 32'(cfg_r.color_offset);
      lssfg_pkg::REG_PALETTE_LEN:  prdata = 32'(cfg_r.palette_len);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.led_count    <= 11'd1;
      cfg_r.stripe_len   <= 11'd1;
      cfg_r.gap_len      <= 11'd0;
      cfg_r.phase_offset <= 11'd0;
      cfg_r.color_offset <= 4'd0;
      cfg_r.palette_len  <= 5'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/lssfg_front.sv =====
// Input stage: accepts words, saturates brightness and packs commands.
// Depends on lssfg_pkg; feeds lssfg_fifo.
module lssfg_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [39:0]     in_data,
  input  logic            in_func,
  output logic            push_valid,
  input  logic            push_ready,
  output lssfg_pkg::cmd_t push_cmd
);

  logic            valid_r, valid_nxt;
  lssfg_pkg::cmd_t cmd_r, cmd_nxt;
  logic [4:0]      br_sat;
  logic            take;

  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_cmd   = cmd_r;

  // Clamp brightness to the 5-bit field
  assign br_sat = (in_data[11:4] > 8'(lssfg_pkg::BR_MAX)) ? lssfg_pkg::BR_MAX : in_data[8:4];

  always_comb begin
    valid_nxt = valid_r;
    cmd_nxt   = cmd_r;
    if (push_ready) valid_nxt = 1'b0;
    if (take) begin
      valid_nxt     = 1'b1;
      cmd_nxt.op    = lssfg_pkg::op_t'(in_func);
      cmd_nxt.idx   = in_data[3:0];
      cmd_nxt.entry = {br_sat, in_data[19:12], in_data[27:20], in_data[35:28]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

// ===== src/lssfg_fifo.sv =====
// Two-entry command queue between the front and back parts.
// Depends on lssfg_pkg.
module lssfg_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            push_ready,
  input  lssfg_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop,
  output lssfg_pkg::cmd_t pop_cmd
);

  lssfg_pkg::cmd_t                mem_r [lssfg_pkg::QDEPTH];
  logic [lssfg_pkg::QPTR_W-1:0]   wptr_r, rptr_r;
  logic [lssfg_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign push_ready = cnt_r != lssfg_pkg::QCNT_W'(lssfg_pkg::QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = mem_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_cmd;
  end

endmodule

// ===== src/lssfg_mod.sv =====
// Iterative remainder unit: phase offset mod period and colour offset mod
// palette length, one restoring step per cycle. Depends on lssfg_pkg.
module lssfg_mod (
  input  logic                clk,
  input  logic                rst_n,
  input  lssfg_pkg::mod_req_t req,
  output lssfg_pkg::mod_rsp_t rsp
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [lssfg_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [lssfg_pkg::CNT_W-1:0]     pdiv_r, pdiv_nxt, cdiv_r, cdiv_nxt;
  logic [lssfg_pkg::PER_W-1:0]     per_r, per_nxt, rem_r, rem_nxt;
  logic [lssfg_pkg::PLEN_W-1:0]    plen_r, plen_nxt, crem_r, crem_nxt;
  logic [lssfg_pkg::PER_W:0]       sh;
  logic [lssfg_pkg::PLEN_W:0]      csh;

  assign sh  = {rem_r, pdiv_r[lssfg_pkg::CNT_W-1]};
  assign csh = {crem_r, cdiv_r[lssfg_pkg::CNT_W-1]};

  assign rsp.done = done_r;
  assign rsp.pat  = (per_r == '0) ? '0 : rem_r;
  assign rsp.col  = crem_r[lssfg_pkg::PIX_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    pdiv_nxt = pdiv_r;
    cdiv_nxt = cdiv_r;
    per_nxt  = per_r;
    rem_nxt  = rem_r;
    plen_nxt = plen_r;
    crem_nxt = crem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      pdiv_nxt = req.phase;
      cdiv_nxt = lssfg_pkg::CNT_W'(req.coff);
      per_nxt  = req.period;
      plen_nxt = req.plen;
      rem_nxt  = '0;
      crem_nxt = '0;
    end else if (busy_r) begin
      // Shift in one dividend bit, subtract the divisor when it fits
      if (sh >= {1'b0, per_r}) rem_nxt = lssfg_pkg::PER_W'(sh - {1'b0, per_r});
      else                     rem_nxt = sh[lssfg_pkg::PER_W-1:0];
      if (csh >= {1'b0, plen_r}) crem_nxt = lssfg_pkg::PLEN_W'(csh - {1'b0, plen_r});
      else                       crem_nxt = csh[lssfg_pkg::PLEN_W-1:0];
      pdiv_nxt = pdiv_r << 1;
      cdiv_nxt = cdiv_r << 1;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == lssfg_pkg::STEP_W'(lssfg_pkg::MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pdiv_r <= pdiv_nxt;
    cdiv_r <= cdiv_nxt;
    per_r  <= per_nxt;
    rem_r  <= rem_nxt;
    plen_r <= plen_nxt;
    crem_r <= crem_nxt;
  end

endmodule

// ===== src/lssfg_back.sv =====
// Back part: palette store, frame sequencer and output register.
// Depends on lssfg_pkg; drives lssfg_mod and pops lssfg_fifo.
module lssfg_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lssfg_pkg::cfg_t                cfg,
  input  logic                           cmd_valid,
  input  lssfg_pkg::cmd_t                cmd,
  output logic                           cmd_pop,
  output lssfg_pkg::mod_req_t            mod_req,
  input  lssfg_pkg::mod_rsp_t            mod_rsp,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lssfg_pkg::WORD_W-1:0]   out_word,
  output lssfg_pkg::kind_t               out_kind,
  output logic                           out_last
);

  lssfg_pkg::back_state_t           state_r, state_nxt;
  logic [lssfg_pkg::ENTRY_W-1:0]    pal_r [lssfg_pkg::PALETTE_DEPTH];
  logic [lssfg_pkg::CNT_W-1:0]      wp_r, wp_nxt;
  logic [lssfg_pkg::PER_W-1:0]      pat_r, pat_nxt, pat_inc, period;
  logic [lssfg_pkg::PIX_W-1:0]      col_r, col_nxt;
  logic [lssfg_pkg::PLEN_W-1:0]     col_inc, plen;
  logic [lssfg_pkg::CNT_W-1:0]      n_eff;
  logic                             ov_r, ov_nxt, ol_r, ol_nxt;
  logic [lssfg_pkg::WORD_W-1:0]     ow_r, ow_nxt;
  lssfg_pkg::kind_t                 ok_r, ok_nxt;
  logic [lssfg_pkg::ENTRY_W-1:0]    ent;
  logic                             can_load, pal_we, lit, mod_start;

  assign out_valid = ov_r;
  assign out_word  = ow_r;
  assign out_kind  = ok_r;
  assign out_last  = ol_r;
  assign can_load  = !ov_r || out_ready;

  assign period = {1'b0, cfg.stripe_len} + {1'b0, cfg.gap_len};
  assign n_eff  = (cfg.led_count > lssfg_pkg::CNT_W'(lssfg_pkg::MAX_LEDS)) ?
                  lssfg_pkg::CNT_W'(lssfg_pkg::MAX_LEDS) : cfg.led_count;
  assign plen   = (cfg.palette_len == '0) ? lssfg_pkg::PLEN_W'(1) :
                  (cfg.palette_len > lssfg_pkg::PLEN_W'(lssfg_pkg::PALETTE_DEPTH)) ?
                  lssfg_pkg::PLEN_W'(lssfg_pkg::PALETTE_DEPTH) : cfg.palette_len;

  assign ent     = pal_r[col_r];
  assign lit     = pat_r < {1'b0, cfg.stripe_len};
  assign pat_inc = pat_r + 1'b1;
  assign col_inc = {1'b0, col_r} + 1'b1;

  assign mod_req.start  = mod_start;
  assign mod_req.period = period;
  assign mod_req.phase  = cfg.phase_offset;
  assign mod_req.coff   = cfg.color_offset;
  assign mod_req.plen   = plen;

  always_comb begin
    state_nxt = state_r;
    wp_nxt    = wp_r;
    pat_nxt   = pat_r;
    col_nxt   = col_r;
    ov_nxt    = ov_r && !out_ready;
    ow_nxt    = ow_r;
    ok_nxt    = ok_r;
    ol_nxt    = ol_r;
    cmd_pop   = 1'b0;
    pal_we    = 1'b0;
    mod_start = 1'b0;
    unique case (state_r)
      lssfg_pkg::ST_RUN: begin
        if (cmd_valid && cmd.op == lssfg_pkg::OP_PAL_WR) begin
          pal_we  = 1'b1;
          cmd_pop = 1'b1;
        end else if (cmd_valid && can_load) begin
          cmd_pop = 1'b1;
          ov_nxt  = 1'b1;
          if (wp_r == '0) begin
            // Start word; reduce the offsets before the first LED
            ow_nxt    = lssfg_pkg::START_WORD;
            ok_nxt    = lssfg_pkg::KIND_START;
            ol_nxt    = 1'b0;
            wp_nxt    = lssfg_pkg::CNT_W'(1);
            mod_start = 1'b1;
            state_nxt = lssfg_pkg::ST_WAIT;
          end else if (wp_r <= n_eff) begin
            ow_nxt = lit ? {lssfg_pkg::LED_HDR, ent[28:24], ent[7:0], ent[15:8], ent[23:16]}
                         : lssfg_pkg::DARK_WORD;
            ok_nxt = lssfg_pkg::KIND_LED;
            ol_nxt = 1'b0;
            wp_nxt = wp_r + 1'b1;
            if (pat_inc >= period) begin
              pat_nxt = '0;
              col_nxt = (col_inc >= plen) ? '0 : col_inc[lssfg_pkg::PIX_W-1:0];
            end else begin
              pat_nxt = pat_inc;
            end
          end else begin
            ow_nxt = lssfg_pkg::END_WORD;
            ok_nxt = lssfg_pkg::KIND_END;
            ol_nxt = 1'b1;
            wp_nxt = '0;
          end
        end
      end
      lssfg_pkg::ST_WAIT: begin
        if (mod_rsp.done) begin
          pat_nxt   = mod_rsp.pat;
          col_nxt   = mod_rsp.col;
          state_nxt = lssfg_pkg::ST_RUN;
        end
      end
      default: state_nxt = lssfg_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lssfg_pkg::ST_RUN;
      wp_r    <= '0;
      pat_r   <= '0;
      col_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      pat_r   <= pat_nxt;
      col_r   <= col_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt;
    ok_r <= ok_nxt;
    ol_r <= ol_nxt;
    if (pal_we) pal_r[cmd.idx] <= cmd.entry;
  end

endmodule

// ===== src/lssfg_checker.sv =====
// Port-level checks on the output stream of the frame generator.
// Depends on lssfg_pkg; bound to led_strip_stripe_frame_generator.
module lssfg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == lssfg_pkg::KIND_END)))
    else $error("tlast not aligned with end word");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lssfg_pkg::KIND_START |-> out_tdata == lssfg_pkg::START_WORD)
    else $error("start word not zero");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lssfg_pkg::KIND_END |-> out_tdata == lssfg_pkg::END_WORD)
    else $error("end word not all ones");

  a_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == lssfg_pkg::KIND_LED |-> out_tdata[31:29] == lssfg_pkg::LED_HDR)
    else $error("LED word header bits wrong");

endmodule

bind led_strip_stripe_frame_generator lssfg_checker u_lssfg_checker (.*);
